### rtl/ecff_pkg.sv
package ecff_pkg;

    localparam int WORD_BITS_DEF = 48;
    localparam int FRAC_BITS_DEF = 16;
    localparam int IO_BITS       = 48;
    localparam int MUL_LAT       = 4;
    localparam int ADDR_BITS     = 3;

    localparam logic REG_FLUX_MODE = 1'b0;

    typedef enum logic [1:0] {
        FAULT_OK        = 2'd0,
        FAULT_ZERO_DENS = 2'd1,
        FAULT_SAT       = 2'd2
    } t_fault;

    typedef struct packed {
        logic zero;
        logic sat_com;
        logic sat_cen;
        logic sat_spl;
    } t_lane_flags;

endpackage

### rtl/ecff_dly.sv
module ecff_dly import ecff_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_sr [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        r_sr[0] <= i_d;
    end

    for (genvar k = 1; k < DEPTH; k++) begin : g_tap
        always_ff @(posedge i_clk) begin
            r_sr[k] <= r_sr[k-1];
        end
    end

    assign o_q = r_sr[DEPTH-1];

endmodule

### rtl/ecff_mul.sv
module ecff_mul import ecff_pkg::*; #(
    parameter int W = WORD_BITS_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W-1:0] o_p,
    output logic                o_sat
);

    localparam int H  = (W + 1) / 2;
    localparam int PW = 2 * W;
    localparam int MW = PW + 1 - F;
    localparam logic [MW-1:0] LIM_P = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [MW-1:0] LIM_N = LIM_P + MW'(1);
    localparam logic [PW:0]   RND   = (PW+1)'(1) << (F - 1);

    logic [W-1:0]    r_ua, r_ub;
    logic            r_neg0, r_neg1, r_neg2;
    logic [2*H-1:0]  r_p00, r_p01, r_p10, r_p11;
    logic [PW-1:0]   r_prod;
    logic [H-1:0]    a_lo, a_hi, b_lo, b_hi;
    logic [PW:0]     rnd;
    logic [MW-1:0]   mag, mag_c;
    logic            sat;

    assign a_lo = r_ua[H-1:0];
    assign b_lo = r_ub[H-1:0];
    assign a_hi = H'(r_ua >> H);
    assign b_hi = H'(r_ub >> H);

    always_comb begin
        rnd = (PW+1)'(r_prod) + RND;
        mag = rnd[PW:F];
        sat = r_neg2 ? (mag > LIM_N) : (mag > LIM_P);
        if (sat) begin
            mag_c = r_neg2 ? LIM_N : LIM_P;
        end else begin
            mag_c = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ua   <= i_a[W-1] ? W'(-i_a) : W'(i_a);
        r_ub   <= i_b[W-1] ? W'(-i_b) : W'(i_b);
        r_neg0 <= i_a[W-1] ^ i_b[W-1];
        r_p00  <= a_lo * b_lo;
        r_p01  <= a_lo * b_hi;
        r_p10  <= a_hi * b_lo;
        r_p11  <= a_hi * b_hi;
        r_neg1 <= r_neg0;
        r_prod <= PW'(r_p00) + (PW'(r_p01) << H) + (PW'(r_p10) << H) + (PW'(r_p11) << (2 * H));
        r_neg2 <= r_neg1;
        o_p    <= r_neg2 ? W'(-mag_c) : W'(mag_c);
        o_sat  <= sat;
    end

endmodule

### rtl/ecff_div.sv
module ecff_div import ecff_pkg::*; #(
    parameter int W = WORD_BITS_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic signed [W-1:0] o_q,
    output logic                o_sat,
    output logic                o_zero
);

    localparam int Q = W + F;
    localparam logic [Q-1:0] LIM_P = {{(Q-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [Q-1:0] LIM_N = LIM_P + Q'(1);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] r_rem  [0:Q];
    logic [Q-1:0] r_num  [0:Q];
    logic [W-1:0] r_den  [0:Q];
    logic         r_neg  [0:Q];
    logic         r_aneg [0:Q];
    logic         r_anz  [0:Q];
    logic         r_zero [0:Q];

    logic [W-1:0] ua, ub;
    logic [Q-1:0] q, q_c;
    logic         sat;

    assign ua = i_num[W-1] ? W'(-i_num) : W'(i_num);
    assign ub = i_den[W-1] ? W'(-i_den) : W'(i_den);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_num[0]  <= {ua, {F{1'b0}}};
        r_den[0]  <= ub;
        r_neg[0]  <= i_num[W-1] ^ i_den[W-1];
        r_aneg[0] <= i_num[W-1];
        r_anz[0]  <= (i_num != '0);
        r_zero[0] <= (i_den == '0);
    end

    // Restoring division, one quotient bit per stage; the quotient shifts in
    // where the dividend bits leave.
    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic [W:0] t, diff;
        logic       ge;
        assign t    = {r_rem[k], r_num[k][Q-1]};
        assign diff = t - {1'b0, r_den[k]};
        assign ge   = (t >= {1'b0, r_den[k]});
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= ge ? diff[W-1:0] : t[W-1:0];
            r_num[k+1]  <= {r_num[k][Q-2:0], ge};
            r_den[k+1]  <= r_den[k];
            r_neg[k+1]  <= r_neg[k];
            r_aneg[k+1] <= r_aneg[k];
            r_anz[k+1]  <= r_anz[k];
            r_zero[k+1] <= r_zero[k];
        end
    end

    always_comb begin
        q   = r_num[Q];
        sat = r_neg[Q] ? (q > LIM_N) : (q > LIM_P);
        if (sat) begin
            q_c = r_neg[Q] ? LIM_N : LIM_P;
        end else begin
            q_c = q;
        end
    end

    always_ff @(posedge i_clk) begin
        o_zero <= r_zero[Q];
        if (r_zero[Q]) begin
            o_sat <= 1'b0;
            if (!r_anz[Q]) begin
                o_q <= '0;
            end else begin
                o_q <= r_aneg[Q] ? WMIN : WMAX;
            end
        end else begin
            o_sat <= sat;
            o_q   <= r_neg[Q] ? W'(-q_c) : W'(q_c);
        end
    end

endmodule

### rtl/ecff_lane.sv
module ecff_lane import ecff_pkg::*; #(
    parameter int W = WORD_BITS_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_rho,
    input  logic signed [W-1:0] i_mom,
    input  logic signed [W-1:0] i_ene,
    input  logic signed [W-1:0] i_pres,
    input  logic signed [W-1:0] i_beta,
    input  logic signed [W-1:0] i_c0f,
    output logic signed [W-1:0] o_a,
    output logic signed [W-1:0] o_k,
    output logic signed [W-1:0] o_p,
    output logic signed [W-1:0] o_i,
    output logic signed [W-1:0] o_s,
    output t_lane_flags         o_flags
);

    localparam int DL = W + F + 2;
    localparam int L  = MUL_LAT;
    localparam logic signed [W:0] SMAX = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W:0] SMIN = {2'b11, {(W-1){1'b0}}};

    function automatic logic [W:0] sadd(input logic signed [W-1:0] a,
                                        input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W+1)'(a) + (W+1)'(b);
        if (s > SMAX) begin
            return {1'b1, SMAX[W-1:0]};
        end else if (s < SMIN) begin
            return {1'b1, SMIN[W-1:0]};
        end
        return {1'b0, s[W-1:0]};
    endfunction

    logic signed [W-1:0] u, u1, u3, m_d, rho_d, p_d, e_d;
    logic signed [W-1:0] a, p, b, k2, c, iv, s_raw;
    logic                div_sat, div_zero, sa, sp, sb, sk2, sc, si, s_sat;
    logic signed [W-1:0] r_ie, r_k;
    logic [1:0]          r_f2, f_u_d, f1_d, f2_d;
    logic [W:0]          ie_sum, s_d;

    ecff_div #(.W(W), .F(F)) u_div (
        .i_clk(i_clk), .i_num(i_mom), .i_den(i_rho),
        .o_q(u), .o_sat(div_sat), .o_zero(div_zero)
    );

    ecff_dly #(.WIDTH(W), .DEPTH(DL)) u_dm (.i_clk(i_clk), .i_d(i_mom), .o_q(m_d));
    ecff_dly #(.WIDTH(W), .DEPTH(DL)) u_dr (.i_clk(i_clk), .i_d(i_rho), .o_q(rho_d));
    ecff_dly #(.WIDTH(W), .DEPTH(DL)) u_dp (.i_clk(i_clk), .i_d(i_pres), .o_q(p_d));
    ecff_dly #(.WIDTH(W), .DEPTH(DL + 2 * L)) u_de (.i_clk(i_clk), .i_d(i_ene), .o_q(e_d));
    ecff_dly #(.WIDTH(W), .DEPTH(L)) u_du1 (.i_clk(i_clk), .i_d(u), .o_q(u1));
    ecff_dly #(.WIDTH(W), .DEPTH(L + 1)) u_du3 (.i_clk(i_clk), .i_d(u1), .o_q(u3));

    ecff_mul #(.W(W), .F(F)) u_mul_a (.i_clk(i_clk), .i_a(m_d), .i_b(u), .o_p(a), .o_sat(sa));
    ecff_mul #(.W(W), .F(F)) u_mul_p (.i_clk(i_clk), .i_a(u), .i_b(p_d), .o_p(p), .o_sat(sp));
    ecff_mul #(.W(W), .F(F)) u_mul_b (.i_clk(i_clk), .i_a(rho_d), .i_b(u), .o_p(b), .o_sat(sb));
    ecff_mul #(.W(W), .F(F)) u_mul_k (.i_clk(i_clk), .i_a(a), .i_b(u1), .o_p(k2), .o_sat(sk2));
    ecff_mul #(.W(W), .F(F)) u_mul_c (.i_clk(i_clk), .i_a(b), .i_b(u1), .o_p(c), .o_sat(sc));
    ecff_mul #(.W(W), .F(F)) u_mul_i (.i_clk(i_clk), .i_a(r_ie), .i_b(u3), .o_p(iv), .o_sat(si));
    ecff_mul #(.W(W), .F(F)) u_mul_s (.i_clk(i_clk), .i_a(i_beta), .i_b(i_c0f),
                                      .o_p(s_raw), .o_sat(s_sat));

    // Internal energy: total energy minus half of rho*u*u.
    assign ie_sum = sadd(e_d, -(c >>> 1));

    always_ff @(posedge i_clk) begin
        r_ie <= ie_sum[W-1:0];
        r_k  <= k2 >>> 1;
        r_f2 <= {sk2, sc | ie_sum[W]};
    end

    ecff_dly #(.WIDTH(2), .DEPTH(3 * L + 1)) u_dfu (
        .i_clk(i_clk), .i_d({div_zero, div_sat}), .o_q(f_u_d));
    ecff_dly #(.WIDTH(2), .DEPTH(2 * L + 1)) u_df1 (
        .i_clk(i_clk), .i_d({sa | sp, sb}), .o_q(f1_d));
    ecff_dly #(.WIDTH(2), .DEPTH(L)) u_df2 (.i_clk(i_clk), .i_d(r_f2), .o_q(f2_d));
    ecff_dly #(.WIDTH(W), .DEPTH(2 * L + 1)) u_da (.i_clk(i_clk), .i_d(a), .o_q(o_a));
    ecff_dly #(.WIDTH(W), .DEPTH(2 * L + 1)) u_dpp (.i_clk(i_clk), .i_d(p), .o_q(o_p));
    ecff_dly #(.WIDTH(W), .DEPTH(L)) u_dk (.i_clk(i_clk), .i_d(r_k), .o_q(o_k));
    ecff_dly #(.WIDTH(W + 1), .DEPTH(DL + 2 * L + 1)) u_ds (
        .i_clk(i_clk), .i_d({s_sat, s_raw}), .o_q(s_d));

    assign o_i             = iv;
    assign o_s             = s_d[W-1:0];
    assign o_flags.zero    = f_u_d[1];
    assign o_flags.sat_com = f_u_d[0] | f1_d[1] | f2_d[1];
    assign o_flags.sat_cen = f1_d[0] | f2_d[0] | si;
    assign o_flags.sat_spl = s_d[W];

endmodule

### rtl/ecff_merge.sv
module ecff_merge import ecff_pkg::*; #(
    parameter int W = WORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_mode,
    input  logic signed [W-1:0]       i_a0, i_a1,
    input  logic signed [W-1:0]       i_k0, i_k1,
    input  logic signed [W-1:0]       i_p0, i_p1,
    input  logic signed [W-1:0]       i_i0, i_i1,
    input  logic signed [W-1:0]       i_s0, i_s1,
    input  t_lane_flags               i_fl0, i_fl1,
    input  logic signed [W-1:0]       i_pif,
    input  logic signed [W-1:0]       i_c0f,
    input  logic                      i_in_sat,
    output logic                      o_done,
    output logic signed [IO_BITS-1:0] o_mass,
    output logic signed [IO_BITS-1:0] o_mom,
    output logic signed [IO_BITS-1:0] o_fe0,
    output logic signed [IO_BITS-1:0] o_fe1,
    output logic [1:0]                o_fault
);

    localparam int XW = ((W > IO_BITS) ? W : IO_BITS) + 1;
    localparam logic signed [W:0] SMAX = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W:0] SMIN = {2'b11, {(W-1){1'b0}}};
    localparam logic signed [XW-1:0] OMAX = {{(XW-IO_BITS+1){1'b0}}, {(IO_BITS-1){1'b1}}};
    localparam logic signed [XW-1:0] OMIN = ~OMAX;

    function automatic logic [W:0] sadd(input logic signed [W-1:0] a,
                                        input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W+1)'(a) + (W+1)'(b);
        if (s > SMAX) begin
            return {1'b1, SMAX[W-1:0]};
        end else if (s < SMIN) begin
            return {1'b1, SMIN[W-1:0]};
        end
        return {1'b0, s[W-1:0]};
    endfunction

    function automatic logic signed [W-1:0] avg(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W+1)'(a) + (W+1)'(b);
        return s[W:1];
    endfunction

    function automatic logic [IO_BITS:0] ofit(input logic signed [W-1:0] x);
        logic signed [XW-1:0] xe;
        xe = XW'(x);
        if (xe > OMAX) begin
            return {1'b1, OMAX[IO_BITS-1:0]};
        end else if (xe < OMIN) begin
            return {1'b1, OMIN[IO_BITS-1:0]};
        end
        return {1'b0, xe[IO_BITS-1:0]};
    endfunction

    logic signed [W-1:0] mf, kf, pf, itf;
    logic [W:0]          fm, t_c, t_s, e0c, e0s, e1s;
    logic signed [W-1:0] r_fmom, r_t1, r_pf, r_s0, r_s1, r_c0f, fe0, fe1;
    logic                r_zero, r_sat, r_v1, sat2;
    logic [IO_BITS:0]    oc_mass, oc_mom, oc_fe0, oc_fe1;
    t_fault              fault;

    always_comb begin
        mf  = avg(i_a0, i_a1);
        kf  = avg(i_k0, i_k1);
        pf  = avg(i_p0, i_p1);
        itf = avg(i_i0, i_i1);
        fm  = sadd(mf, i_pif);
        t_c = sadd(kf, itf);
        t_s = sadd(kf, pf);
    end

    always_ff @(posedge i_clk) begin
        r_fmom <= fm[W-1:0];
        r_t1   <= i_mode ? t_s[W-1:0] : t_c[W-1:0];
        r_pf   <= pf;
        r_s0   <= i_s0;
        r_s1   <= i_s1;
        r_c0f  <= i_c0f;
        r_zero <= i_fl0.zero | i_fl1.zero;
        r_sat  <= i_in_sat | i_fl0.sat_com | i_fl1.sat_com | fm[W]
                | (i_mode ? (i_fl0.sat_spl | i_fl1.sat_spl | t_s[W])
                          : (i_fl0.sat_cen | i_fl1.sat_cen | t_c[W]));
    end

    always_comb begin
        e0c  = sadd(r_t1, r_pf);
        e0s  = sadd(r_t1, r_s0);
        e1s  = sadd(r_t1, r_s1);
        fe0  = i_mode ? e0s[W-1:0] : e0c[W-1:0];
        fe1  = i_mode ? e1s[W-1:0] : e0c[W-1:0];
        sat2 = i_mode ? (e0s[W] | e1s[W]) : e0c[W];
        oc_mass = ofit(r_c0f);
        oc_mom  = ofit(r_fmom);
        oc_fe0  = ofit(fe0);
        oc_fe1  = ofit(fe1);
        if (r_zero) begin
            fault = FAULT_ZERO_DENS;
        end else if (r_sat | sat2 | oc_mass[IO_BITS] | oc_mom[IO_BITS]
                     | oc_fe0[IO_BITS] | oc_fe1[IO_BITS]) begin
            fault = FAULT_SAT;
        end else begin
            fault = FAULT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        o_mass  <= oc_mass[IO_BITS-1:0];
        o_mom   <= oc_mom[IO_BITS-1:0];
        o_fe0   <= oc_fe0[IO_BITS-1:0];
        o_fe1   <= oc_fe1[IO_BITS-1:0];
        o_fault <= fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= i_valid;
            o_done <= r_v1;
        end
    end

endmodule

### rtl/euler_central_face_flux_core.sv
// Fully pipelined: one transaction is accepted every cycle and busy never rises.
// o_done marks each result after the bit-per-stage divider and three multiplier
// levels of four stages each (default word/fraction widths 48/16).
// The receiver cannot stall; results show for one cycle under o_done.
// Synchronous active-low reset clears the pipeline valids and flux_mode.
module euler_central_face_flux_core import ecff_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [46:0]               i_left_density,
    input  logic [46:0]               i_right_density,
    input  logic signed [IO_BITS-1:0] i_left_momentum,
    input  logic signed [IO_BITS-1:0] i_right_momentum,
    input  logic signed [IO_BITS-1:0] i_left_energy,
    input  logic signed [IO_BITS-1:0] i_right_energy,
    input  logic signed [IO_BITS-1:0] i_left_pressure,
    input  logic signed [IO_BITS-1:0] i_right_pressure,
    input  logic signed [IO_BITS-1:0] i_left_beta,
    input  logic signed [IO_BITS-1:0] i_right_beta,
    output logic                      o_done,
    output logic signed [IO_BITS-1:0] o_mass_flux,
    output logic signed [IO_BITS-1:0] o_momentum_flux,
    output logic signed [IO_BITS-1:0] o_left_energy_flux,
    output logic signed [IO_BITS-1:0] o_right_energy_flux,
    output logic                      o_species_flux,
    output logic [1:0]                o_fault_code,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_BITS-1:0]      paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int W  = WORD_BITS;
    localparam int CL = W + FRAC_BITS + 2 + 3 * MUL_LAT + 2;
    localparam int XW = ((W > IO_BITS) ? W : IO_BITS) + 1;
    localparam logic signed [XW-1:0] WLIM_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] WLIM_LO = ~WLIM_HI;

    function automatic logic [W:0] fit_in(input logic signed [IO_BITS-1:0] x);
        logic signed [XW-1:0] xe;
        xe = XW'(x);
        if (xe > WLIM_HI) begin
            return {1'b1, WLIM_HI[W-1:0]};
        end else if (xe < WLIM_LO) begin
            return {1'b1, WLIM_LO[W-1:0]};
        end
        return {1'b0, xe[W-1:0]};
    endfunction

    logic          accept, cfg_wr, r_mode;
    logic [CL-1:0] r_vld;
    logic [W:0]    f_r0, f_r1, f_m0, f_m1, f_e0, f_e1, f_p0, f_p1, f_b0, f_b1;
    logic signed [W-1:0] r_r0, r_r1, r_m0, r_m1, r_e0, r_e1, r_p0, r_p1, r_b0, r_b1;
    logic                r_in_sat, in_sat_d;
    logic signed [W:0]   c0f_s, pif_s;
    logic signed [W-1:0] c0f, pif, c0f_d, pif_d;
    logic signed [W-1:0] a0, a1, k0, k1, p0, p1, i0, i1, s0, s1;
    t_lane_flags         fl0, fl1;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start & ~busy;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_FLUX_MODE) ? {31'b0, r_mode} : 32'b0;
    assign o_species_flux = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_vld  <= '0;
        end else begin
            if (cfg_wr && paddr[2] == REG_FLUX_MODE) begin
                r_mode <= pwdata[0];
            end
            r_vld <= {r_vld[CL-2:0], accept};
        end
    end

    always_comb begin
        f_r0 = fit_in({1'b0, i_left_density});
        f_r1 = fit_in({1'b0, i_right_density});
        f_m0 = fit_in(i_left_momentum);
        f_m1 = fit_in(i_right_momentum);
        f_e0 = fit_in(i_left_energy);
        f_e1 = fit_in(i_right_energy);
        f_p0 = fit_in(i_left_pressure);
        f_p1 = fit_in(i_right_pressure);
        f_b0 = fit_in(i_left_beta);
        f_b1 = fit_in(i_right_beta);
    end

    always_ff @(posedge i_clk) begin
        r_r0 <= f_r0[W-1:0];
        r_r1 <= f_r1[W-1:0];
        r_m0 <= f_m0[W-1:0];
        r_m1 <= f_m1[W-1:0];
        r_e0 <= f_e0[W-1:0];
        r_e1 <= f_e1[W-1:0];
        r_p0 <= f_p0[W-1:0];
        r_p1 <= f_p1[W-1:0];
        r_b0 <= f_b0[W-1:0];
        r_b1 <= f_b1[W-1:0];
        r_in_sat <= f_r0[W] | f_r1[W] | f_m0[W] | f_m1[W] | f_e0[W] | f_e1[W]
                  | f_p0[W] | f_p1[W] | f_b0[W] | f_b1[W];
    end

    // Floor averages of the momenta (mass flux) and of the pressures.
    assign c0f_s = (W+1)'(r_m0) + (W+1)'(r_m1);
    assign pif_s = (W+1)'(r_p0) + (W+1)'(r_p1);
    assign c0f   = c0f_s[W:1];
    assign pif   = pif_s[W:1];

    ecff_dly #(.WIDTH(2 * W + 1), .DEPTH(CL - 1)) u_dly_face (
        .i_clk(i_clk), .i_d({r_in_sat, c0f, pif}), .o_q({in_sat_d, c0f_d, pif_d}));

    ecff_lane #(.W(W), .F(FRAC_BITS)) u_lane_l (
        .i_clk(i_clk), .i_rho(r_r0), .i_mom(r_m0), .i_ene(r_e0), .i_pres(r_p0),
        .i_beta(r_b0), .i_c0f(c0f),
        .o_a(a0), .o_k(k0), .o_p(p0), .o_i(i0), .o_s(s0), .o_flags(fl0)
    );

    ecff_lane #(.W(W), .F(FRAC_BITS)) u_lane_r (
        .i_clk(i_clk), .i_rho(r_r1), .i_mom(r_m1), .i_ene(r_e1), .i_pres(r_p1),
        .i_beta(r_b1), .i_c0f(c0f),
        .o_a(a1), .o_k(k1), .o_p(p1), .o_i(i1), .o_s(s1), .o_flags(fl1)
    );

    ecff_merge #(.W(W)) u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vld[CL-1]), .i_mode(r_mode),
        .i_a0(a0), .i_a1(a1), .i_k0(k0), .i_k1(k1), .i_p0(p0), .i_p1(p1),
        .i_i0(i0), .i_i1(i1), .i_s0(s0), .i_s1(s1), .i_fl0(fl0), .i_fl1(fl1),
        .i_pif(pif_d), .i_c0f(c0f_d), .i_in_sat(in_sat_d),
        .o_done(o_done), .o_mass(o_mass_flux), .o_mom(o_momentum_flux),
        .o_fe0(o_left_energy_flux), .o_fe1(o_right_energy_flux), .o_fault(o_fault_code)
    );

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");

    a_done_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_vld[CL-1], 2))
        else $error("result strobe without a matching transaction");

    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[2] == REG_FLUX_MODE) |=> (r_mode == $past(pwdata[0])))
        else $error("flux_mode write lost");

endmodule

### dv/euler_central_face_flux_core_tb.sv
module euler_central_face_flux_core_tb;
    import ecff_pkg::*;

    localparam longint WMAX = (64'sd1 <<< 47) - 1;
    localparam longint WMIN = -(64'sd1 <<< 47);
    localparam longint ONE = 64'sd65536;
    localparam logic [ADDR_BITS-1:0] ADDR_FLUX_MODE = ADDR_BITS'(4 * REG_FLUX_MODE);
    localparam int LATENCY = WORD_BITS_DEF + FRAC_BITS_DEF + 18;
    localparam int N_RANDOM = 1830;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        longint rho_l, rho_r, mom_l, mom_r, en_l, en_r, pr_l, pr_r, beta_l, beta_r;
    } t_face;

    typedef struct {
        longint mass, mom, en_l, en_r;
        logic   species;
        t_fault fault;
    } t_flux;

    typedef struct {
        t_face face;
        bit    mode;
        bit    known;
        t_flux flux;
    } t_row;

    logic i_clk, i_rst_n, start, busy, o_done, o_species_flux;
    logic [46:0] i_left_density, i_right_density;
    logic signed [IO_BITS-1:0] i_left_momentum, i_right_momentum, i_left_energy,
        i_right_energy, i_left_pressure, i_right_pressure, i_left_beta, i_right_beta;
    logic signed [IO_BITS-1:0] o_mass_flux, o_momentum_flux, o_left_energy_flux,
        o_right_energy_flux;
    logic [1:0] o_fault_code;
    logic psel, penable, pwrite, pready;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata, prdata;

    euler_central_face_flux_core dut (.*);

    bit     mode_q;
    bit     sat_seen, zero_seen;
    t_flux  pending_q[$];
    t_row   directed_q[$];
    int     errors, faces_sent, results_seen, mode_faces[2], fault_seen[3];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Fixed-point helpers; saturation and zero-divisor events latch into flags.
    function automatic longint clamp_word(t_wide x);
        if (x > t_wide'(WMAX)) begin
            sat_seen = 1'b1;
            return WMAX;
        end
        if (x < t_wide'(WMIN)) begin
            sat_seen = 1'b1;
            return WMIN;
        end
        return longint'(x);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        t_wide p, m;
        p = t_wide'(a) * t_wide'(b);
        m = (p < 0) ? -p : p;
        m = (m + 128'sd32768) >>> 16;
        return clamp_word(((a < 0) != (b < 0)) ? -m : m);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        t_wide ma, mb, q;
        if (b == 0) begin
            zero_seen = 1'b1;
            return (a > 0) ? WMAX : ((a < 0) ? WMIN : 64'sd0);
        end
        ma = (a < 0) ? -t_wide'(a) : t_wide'(a);
        mb = (b < 0) ? -t_wide'(b) : t_wide'(b);
        q = (ma <<< 16) / mb;
        return clamp_word(((a < 0) != (b < 0)) ? -q : q);
    endfunction

    function automatic longint fx_half(longint x);
        return x >>> 1;
    endfunction

    function automatic longint fx_avg(longint a, longint b);
        t_wide s;
        s = t_wide'(a) + t_wide'(b);
        return longint'(s >>> 1);
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return clamp_word(t_wide'(a) + t_wide'(b));
    endfunction

    function automatic t_flux face_flux(t_face f, bit split);
        t_flux  r;
        longint u_l, u_r, mass, kin, pw, base, ie_l, ie_r, itf;
        sat_seen = 1'b0;
        zero_seen = 1'b0;
        u_l = fx_div(f.mom_l, f.rho_l);
        u_r = fx_div(f.mom_r, f.rho_r);
        mass = fx_avg(f.mom_l, f.mom_r);
        r.mom = fx_add(fx_avg(fx_mul(f.mom_l, u_l), fx_mul(f.mom_r, u_r)),
                       fx_avg(f.pr_l, f.pr_r));
        kin = fx_avg(fx_half(fx_mul(fx_mul(f.mom_l, u_l), u_l)),
                     fx_half(fx_mul(fx_mul(f.mom_r, u_r), u_r)));
        pw = fx_avg(fx_mul(u_l, f.pr_l), fx_mul(u_r, f.pr_r));
        if (!split) begin
            ie_l = fx_add(f.en_l, -fx_half(fx_mul(fx_mul(f.rho_l, u_l), u_l)));
            ie_r = fx_add(f.en_r, -fx_half(fx_mul(fx_mul(f.rho_r, u_r), u_r)));
            itf = fx_avg(fx_mul(ie_l, u_l), fx_mul(ie_r, u_r));
            r.en_l = fx_add(fx_add(kin, itf), pw);
            r.en_r = r.en_l;
        end else begin
            base = fx_add(kin, pw);
            r.en_l = fx_add(base, fx_mul(f.beta_l, mass));
            r.en_r = fx_add(base, fx_mul(f.beta_r, mass));
        end
        r.mass = mass;
        r.species = 1'b0;
        r.fault = zero_seen ? FAULT_ZERO_DENS : (sat_seen ? FAULT_SAT : FAULT_OK);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    always @(posedge i_clk) begin
        t_flux w;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                report("unexpected transaction", 1, 0);
            end else begin
                w = pending_q.pop_front();
                if (o_mass_flux !== w.mass[47:0]) report("mass_flux", o_mass_flux, w.mass);
                if (o_momentum_flux !== w.mom[47:0])
                    report("momentum_flux", o_momentum_flux, w.mom);
                if (o_left_energy_flux !== w.en_l[47:0])
                    report("left_energy_flux", o_left_energy_flux, w.en_l);
                if (o_right_energy_flux !== w.en_r[47:0])
                    report("right_energy_flux", o_right_energy_flux, w.en_r);
                if (o_species_flux !== w.species) report("species_flux", o_species_flux, 0);
                if (o_fault_code !== w.fault) report("fault_code", o_fault_code, w.fault);
            end
        end
    end

    task automatic drain();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_FLUX_MODE;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mode_q = value[0];
    endtask

    // Leaves start high; the caller lowers it for a gap or drives the next face.
    task automatic send_face(t_face f, bit known, t_flux want);
        t_flux p;
        start <= 1'b1;
        i_left_density <= f.rho_l[46:0];
        i_right_density <= f.rho_r[46:0];
        i_left_momentum <= f.mom_l[47:0];
        i_right_momentum <= f.mom_r[47:0];
        i_left_energy <= f.en_l[47:0];
        i_right_energy <= f.en_r[47:0];
        i_left_pressure <= f.pr_l[47:0];
        i_right_pressure <= f.pr_r[47:0];
        i_left_beta <= f.beta_l[47:0];
        i_right_beta <= f.beta_r[47:0];
        do @(posedge i_clk); while (busy);
        p = face_flux(f, mode_q);
        pending_q.insert(pending_q.size(), known ? want : p);
        faces_sent++;
        mode_faces[mode_q]++;
        fault_seen[p.fault]++;
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 60) return;
        start <= 1'b0;
        if (n < 95) repeat ($urandom_range(1, 3)) @(posedge i_clk);
        else repeat ($urandom_range(10, 120)) @(posedge i_clk);
    endtask

    function automatic longint raw48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return longint'(signed'(v[47:0]));
    endfunction

    function automatic longint pick(longint lo, longint hi);
        return lo + longint'({$urandom, $urandom} % (hi - lo + 1));
    endfunction

    // Mostly physical states with random content, some raw noise and some empty cells.
    function automatic t_face random_face();
        t_face f;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            f.rho_l = pick(ONE / 64, 2000 * ONE);
            f.rho_r = pick(ONE / 64, 2000 * ONE);
            f.mom_l = pick(-5000 * ONE, 5000 * ONE);
            f.mom_r = pick(-5000 * ONE, 5000 * ONE);
            f.en_l = pick(0, 100000 * ONE);
            f.en_r = pick(0, 100000 * ONE);
            f.pr_l = pick(0, 40000 * ONE);
            f.pr_r = pick(0, 40000 * ONE);
            f.beta_l = pick(-10 * ONE, 10 * ONE);
            f.beta_r = pick(-10 * ONE, 10 * ONE);
        end else begin
            f.rho_l = raw48() & WMAX;
            f.rho_r = raw48() & WMAX;
            f.mom_l = raw48();
            f.mom_r = raw48();
            f.en_l = raw48();
            f.en_r = raw48();
            f.pr_l = raw48();
            f.pr_r = raw48();
            f.beta_l = raw48();
            f.beta_r = raw48();
        end
        if (kind == 9) begin
            if ($urandom_range(0, 1)) f.rho_l = 0;
            else f.rho_r = 0;
        end
        return f;
    endfunction

    task automatic add_row(bit mode, longint rl, longint rr, longint ml, longint mr,
                           longint el, longint er, longint pl, longint pr,
                           longint bl, longint br);
        t_row r;
        r.face = '{rl, rr, ml, mr, el, er, pl, pr, bl, br};
        r.mode = mode;
        r.known = 1'b0;
        directed_q.insert(directed_q.size(), r);
    endtask

    task automatic add_known(bit mode, t_face f, t_flux w);
        t_row r;
        r.face = f;
        r.mode = mode;
        r.known = 1'b1;
        r.flux = w;
        directed_q.insert(directed_q.size(), r);
    endtask

    task automatic build_directed();
        t_face f;
        f = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        add_known(0, f, '{0, 0, 0, 0, 1'b0, FAULT_ZERO_DENS});
        f = '{ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0};
        add_known(0, f, '{0, 0, 0, 0, 1'b0, FAULT_OK});
        f = '{ONE, ONE, 0, 0, 0, 0, ONE, ONE, 0, 0};
        add_known(0, f, '{0, ONE, 0, 0, 1'b0, FAULT_OK});
        add_row(0, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0, 0);
        add_row(0, 0, ONE, WMIN, ONE, 0, 0, 0, 0, 0, 0);
        add_row(0, ONE, 0, WMAX, WMAX, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
        add_row(0, 1, 1, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0, 0);
        add_row(0, 2 * ONE, 3 * ONE, 3 * ONE, -5 * ONE, 20 * ONE, 30 * ONE,
                ONE, 2 * ONE, 0, 0);
        add_row(0, ONE, ONE, -1, 1, -1, 1, -1, 1, 0, 0);
        add_row(1, 2 * ONE, 3 * ONE, 3 * ONE, -5 * ONE, 20 * ONE, 30 * ONE,
                ONE, 2 * ONE, ONE / 2, -3 * ONE);
        add_row(1, ONE, ONE, 1000 * ONE, 1000 * ONE, 0, 0, 0, 0, WMAX, WMIN);
        add_row(1, ONE, ONE, -1000 * ONE, -1000 * ONE, WMAX, WMIN, 0, 0, WMIN, WMAX);
        add_row(1, 0, 0, ONE, -ONE, 0, 0, ONE, ONE, ONE, ONE);
        add_row(1, WMAX, 1, WMIN, WMAX, 0, 0, WMAX, WMAX, 1, -1);
    endtask

    initial begin
        t_row  r;
        t_flux none;
        int    phase;
        i_rst_n = 1'b0;
        start = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        {i_left_density, i_right_density} = '0;
        {i_left_momentum, i_right_momentum, i_left_energy, i_right_energy} = '0;
        {i_left_pressure, i_right_pressure, i_left_beta, i_right_beta} = '0;
        mode_q = 1'b0;
        none = '{0, 0, 0, 0, 1'b0, FAULT_OK};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        build_directed();

        foreach (directed_q[k]) begin
            r = directed_q[k];
            if (r.mode != mode_q) begin
                start <= 1'b0;
                drain();
                write_mode({31'h0, r.mode});
            end
            send_face(r.face, r.known, r.flux);
            idle_gap();
        end

        // Random phases, each under a fresh mode; upper data bits are junk.
        for (phase = 0; phase < 6; phase++) begin
            start <= 1'b0;
            drain();
            write_mode({31'($urandom_range(0, 32'h7fffffff)), phase[0] ^ 1'b1});
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                send_face(random_face(), 1'b0, none);
                if (phase == 2 && k == 150) begin
                    start <= 1'b0;
                    drain();
                end else if (phase % 3 != 1) begin
                    idle_gap();
                end
            end
        end
        start <= 1'b0;

        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("Faces sent %0d (central %0d, split %0d), results %0d.",
                 faces_sent, mode_faces[0], mode_faces[1], results_seen);
        $display("Predicted faults: ok %0d, zero density %0d, saturated %0d.",
                 fault_seen[0], fault_seen[1], fault_seen[2]);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/ecff_pkg.sv
rtl/ecff_dly.sv
rtl/ecff_mul.sv
rtl/ecff_div.sv
rtl/ecff_lane.sv
rtl/ecff_merge.sv
rtl/euler_central_face_flux_core.sv
dv/euler_central_face_flux_core_tb.sv
